[src/lbas_pkg.sv]
// Shared types, constants and helper functions for the LED bar animation sequencer.
package lbas_pkg;

    localparam int LED_COUNT  = 8;
    localparam int POS_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int PATTERN_W  = 8;
    localparam int ACTION_W   = 3;
    localparam int MODE_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int ELAPSED_W  = 16;
    localparam int BLINK_W    = 8;
    localparam int PHASE_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEPART = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ARRIVE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UP     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DOWN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_TRANS    = 2'd3;

    localparam logic [INTERVAL_W-1:0] RUN_INTERVAL_RST   = 16'd250;
    localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd250;
    localparam logic [INTERVAL_W-1:0] HALF_PERIOD_RST    = 16'd500;
    localparam logic [BLINK_W-1:0]    BLINK_TRANS_RST    = 8'd6;

    localparam logic [PATTERN_W-1:0] PATTERN_ALL_ON  = 8'hFF;
    localparam logic [PATTERN_W-1:0] PATTERN_ALL_OFF = 8'h00;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 3'd0,
        MODE_DEPART = 3'd1,
        MODE_ARRIVE = 3'd2,
        MODE_UP     = 3'd3,
        MODE_DOWN   = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [POS_W-1:0]     band_pos;
        logic [ELAPSED_W-1:0] elapsed;
        logic [BLINK_W-1:0]   blink_count;
        logic [PHASE_W-1:0]   phase;
    } anim_state_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] run_interval;
        logic [INTERVAL_W-1:0] blink_interval;
        logic [INTERVAL_W-1:0] half_period;
        logic [BLINK_W-1:0]    blink_trans;
    } cfg_t;

    typedef struct packed {
        logic                 emit;
        logic [PATTERN_W-1:0] pattern;
        mode_t                mode;
    } result_t;

    function automatic logic [POS_W-1:0] pos_up(input logic [POS_W-1:0] p);
        logic [POS_W:0] s;
        s = {1'b0, p} + (POS_W + 1)'(1);
        return (s >= (POS_W + 1)'(LED_COUNT)) ? '0 : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_down(input logic [POS_W-1:0] p);
        return (p == '0) ? POS_W'(LED_COUNT - 1) : p - POS_W'(1);
    endfunction

    // Positions beyond the byte are dropped.
    function automatic logic [PATTERN_W-1:0] led_bit(input logic [POS_W-1:0] p);
        logic [PATTERN_W-1:0] r;
        for (int i = 0; i < PATTERN_W; i++) begin
            r[i] = (32'(p) == 32'(i));
        end
        return r;
    endfunction

endpackage

[src/lbas_step.sv]
// Combinational step logic: next animation state and result for one request.
module lbas_step (
    input  lbas_pkg::anim_state_t             st,
    input  lbas_pkg::cfg_t                    cfg,
    input  logic [lbas_pkg::ACTION_W-1:0]     action,
    input  logic                              emergency,
    output lbas_pkg::anim_state_t             st_next,
    output lbas_pkg::result_t                 res
);
    import lbas_pkg::*;

    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic [INTERVAL_W-1:0] interval;
    logic                  blink_mode;
    logic                  step_due;
    logic [INTERVAL_W-1:0] half_eff;
    logic [PHASE_W-1:0]    two_half;
    logic [PHASE_W-1:0]    phase_wrap;
    logic [PHASE_W:0]      phase_inc;
    logic [PHASE_W-1:0]    phase_adv;
    logic                  flash_on;
    logic [BLINK_W-1:0]    blink_inc;
    logic                  blink_done;
    logic [POS_W-1:0]      pos_b;
    logic [POS_W-1:0]      pos_c;
    logic [PATTERN_W-1:0]  band_pattern;

    assign elapsed_inc = (st.elapsed == '1) ? st.elapsed : st.elapsed + ELAPSED_W'(1);
    assign blink_mode  = (st.mode == MODE_DEPART) || (st.mode == MODE_ARRIVE);
    assign interval    = blink_mode ? cfg.blink_interval : cfg.run_interval;
    assign step_due    = (elapsed_inc >= interval);

    assign half_eff   = (cfg.half_period == '0) ? INTERVAL_W'(1) : cfg.half_period;
    assign two_half   = {half_eff, 1'b0};
    assign phase_wrap = (st.phase >= two_half) ? '0 : st.phase;
    assign phase_inc  = {1'b0, phase_wrap} + (PHASE_W + 1)'(1);
    assign phase_adv  = (phase_inc >= {1'b0, two_half}) ? '0 : phase_inc[PHASE_W-1:0];
    assign flash_on   = (phase_wrap < {1'b0, half_eff});

    assign blink_inc  = st.blink_count + BLINK_W'(1);
    assign blink_done = !(blink_inc < cfg.blink_trans);

    assign pos_b = (st.mode == MODE_UP) ? pos_down(st.band_pos) : pos_up(st.band_pos);
    assign pos_c = (st.mode == MODE_UP) ? pos_down(pos_b) : pos_up(pos_b);
    assign band_pattern = led_bit(st.band_pos) | led_bit(pos_b) | led_bit(pos_c);

    always_comb begin
        st_next = st;
        case (action)
            ACT_DEPART, ACT_ARRIVE: begin
                st_next.mode        = mode_t'(action);
                st_next.blink_count = '0;
                st_next.elapsed     = '0;
            end
            ACT_UP: begin
                st_next.mode     = MODE_UP;
                st_next.band_pos = '0;
                st_next.elapsed  = '0;
            end
            ACT_DOWN: begin
                st_next.mode     = MODE_DOWN;
                st_next.band_pos = POS_W'(LED_COUNT - 1);
                st_next.elapsed  = '0;
            end
            ACT_TICK: begin
                st_next.elapsed = elapsed_inc;
                if (emergency) begin
                    st_next.phase = phase_adv;
                end else if (step_due) begin
                    case (st.mode)
                        MODE_DEPART, MODE_ARRIVE: begin
                            st_next.elapsed     = '0;
                            st_next.blink_count = blink_inc;
                            if (blink_done) begin
                                st_next.mode = MODE_IDLE;
                            end
                        end
                        MODE_UP: begin
                            st_next.elapsed  = '0;
                            st_next.band_pos = pos_up(st.band_pos);
                        end
                        MODE_DOWN: begin
                            st_next.elapsed  = '0;
                            st_next.band_pos = pos_down(st.band_pos);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.emit    = 1'b0;
        res.pattern = PATTERN_ALL_OFF;
        res.mode    = st_next.mode;
        case (action)
            ACT_DEPART, ACT_ARRIVE: begin
                res.emit    = 1'b1;
                res.pattern = PATTERN_ALL_ON;
            end
            ACT_TICK: begin
                if (emergency) begin
                    res.emit    = 1'b1;
                    res.pattern = flash_on ? PATTERN_ALL_ON : PATTERN_ALL_OFF;
                end else if (step_due) begin
                    case (st.mode)
                        MODE_DEPART, MODE_ARRIVE: begin
                            res.emit = 1'b1;
                            if (blink_done) begin
                                res.pattern = (st.mode == MODE_DEPART) ? PATTERN_ALL_ON
                                                                       : PATTERN_ALL_OFF;
                            end else begin
                                res.pattern = blink_inc[0] ? PATTERN_ALL_OFF : PATTERN_ALL_ON;
                            end
                        end
                        MODE_UP, MODE_DOWN: begin
                            res.emit    = 1'b1;
                            res.pattern = band_pattern;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/led_bar_animation_sequencer.sv]
// Top level of the LED bar animation sequencer: request and result registers, state, config.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   s_action[2:0], s_emergency
//   m_        out        m_valid/m_ready   m_pattern[7:0], m_mode[2:0]
//   cfg_      in         cfg_we            cfg_index[1:0], cfg_wdata[15:0]
//
// One request is taken per cycle unless the output stalls; not every request emits a result.
// The rate is set by the single step from the request register through the step logic
// into the result register, which also updates the animation state.
// Synchronous active-low reset returns the config, state and valid registers to their defaults and the mode to idle.
// A stalled result holds the request register, and s_ready drops once both are full.
module led_bar_animation_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lbas_pkg::ACTION_W-1:0]       s_action,
    input  logic                                s_emergency,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lbas_pkg::PATTERN_W-1:0]      m_pattern,
    output logic [lbas_pkg::MODE_W-1:0]         m_mode,
    input  logic                                cfg_we,
    input  logic [lbas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lbas_pkg::*;

    cfg_t                 cfg_reg;
    anim_state_t          st_reg;
    anim_state_t          st_next;
    result_t              res;
    logic                 in_valid_reg;
    logic [ACTION_W-1:0]  in_action_reg;
    logic                 in_emergency_reg;
    logic                 m_valid_reg;
    logic [PATTERN_W-1:0] m_pattern_reg;
    logic [MODE_W-1:0]    m_mode_reg;
    logic                 out_free;
    logic                 proc;

    assign out_free = !m_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || proc;

    assign m_valid   = m_valid_reg;
    assign m_pattern = m_pattern_reg;
    assign m_mode    = m_mode_reg;

    lbas_step u_step (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .action    (in_action_reg),
        .emergency (in_emergency_reg),
        .st_next   (st_next),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_interval   <= RUN_INTERVAL_RST;
            cfg_reg.blink_interval <= BLINK_INTERVAL_RST;
            cfg_reg.half_period    <= HALF_PERIOD_RST;
            cfg_reg.blink_trans    <= BLINK_TRANS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RUN_INTERVAL:   cfg_reg.run_interval   <= cfg_wdata;
                REG_BLINK_INTERVAL: cfg_reg.blink_interval <= cfg_wdata;
                REG_HALF_PERIOD:    cfg_reg.half_period    <= cfg_wdata;
                REG_BLINK_TRANS:    cfg_reg.blink_trans    <= cfg_wdata[BLINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= '{mode: MODE_IDLE, default: '0};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                st_reg      <= st_next;
                m_valid_reg <= res.emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg    <= s_action;
            in_emergency_reg <= s_emergency;
        end
        if (proc && res.emit) begin
            m_pattern_reg <= res.pattern;
            m_mode_reg    <= res.mode;
        end
    end

    a_band_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(st_reg.band_pos) < LED_COUNT)
        else $error("Band position left the bar.");

    a_depart_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_action_reg == ACT_DEPART) |=>
            (m_valid_reg && m_pattern_reg == PATTERN_ALL_ON && m_mode_reg == MODE_DEPART))
        else $error("Start depart did not present a full bar in depart mode.");

    a_up_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_action_reg == ACT_UP) |=>
            (st_reg.mode == MODE_UP && st_reg.band_pos == '0 && st_reg.elapsed == '0))
        else $error("Start up did not reset the band animation.");

    a_stall_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(st_reg))
        else $error("Animation state advanced while a result was stalled.");

endmodule

[test/testbench.sv]
// Self-checking testbench for the LED bar animation sequencer with its own step predictor.
`timescale 1ns / 1ps

module testbench;
    import lbas_pkg::*;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic                emergency;
    } bar_request_t;

    typedef struct {
        logic [PATTERN_W-1:0] pattern;
        logic [MODE_W-1:0]    mode;
    } bar_frame_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action = ACT_TICK;
    logic                  s_emergency = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PATTERN_W-1:0]  m_pattern;
    logic [MODE_W-1:0]     m_mode;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RUN_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bar_request_t pending_requests[$];
    bar_frame_t   expected_frames[$];
    int           mismatches = 0;

    logic [INTERVAL_W-1:0] run_iv = RUN_INTERVAL_RST;
    logic [INTERVAL_W-1:0] blink_iv = BLINK_INTERVAL_RST;
    logic [INTERVAL_W-1:0] flash_half = HALF_PERIOD_RST;
    logic [BLINK_W-1:0]    blink_limit = BLINK_TRANS_RST;

    mode_t                 bar_mode = MODE_IDLE;
    int unsigned           bar_pos = 0;
    logic [ELAPSED_W-1:0]  bar_elapsed = '0;
    logic [BLINK_W-1:0]    bar_blinks = '0;
    int unsigned           bar_phase = 0;

    led_bar_animation_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_emergency (s_emergency),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pattern   (m_pattern),
        .m_mode      (m_mode),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [PATTERN_W-1:0] band_bits(input int unsigned p, input int dir);
        logic [PATTERN_W-1:0] r;
        int                   idx;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            idx = (int'(p) + 3 * LED_COUNT + dir * k) % LED_COUNT;
            if (idx < PATTERN_W) begin
                r[idx] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic advance_bar_model(input logic [ACTION_W-1:0] act, input logic emerg);
        logic                 emit;
        logic [PATTERN_W-1:0] pat;
        int unsigned          half;
        bar_frame_t           frame;
        emit = 1'b0;
        pat = PATTERN_ALL_OFF;
        case (act)
            ACT_DEPART, ACT_ARRIVE: begin
                bar_mode = (act == ACT_DEPART) ? MODE_DEPART : MODE_ARRIVE;
                bar_blinks = '0;
                bar_elapsed = '0;
                pat = PATTERN_ALL_ON;
                emit = 1'b1;
            end
            ACT_UP: begin
                bar_mode = MODE_UP;
                bar_pos = 0;
                bar_elapsed = '0;
            end
            ACT_DOWN: begin
                bar_mode = MODE_DOWN;
                bar_pos = LED_COUNT - 1;
                bar_elapsed = '0;
            end
            ACT_TICK: begin
                if (bar_elapsed != '1) begin
                    bar_elapsed = bar_elapsed + 1'b1;
                end
                if (emerg) begin
                    half = (flash_half == '0) ? 1 : flash_half;
                    if (bar_phase >= 2 * half) begin
                        bar_phase = 0;
                    end
                    pat = (bar_phase < half) ? PATTERN_ALL_ON : PATTERN_ALL_OFF;
                    bar_phase = (bar_phase + 1 >= 2 * half) ? 0 : bar_phase + 1;
                    emit = 1'b1;
                end else if (bar_mode == MODE_DEPART || bar_mode == MODE_ARRIVE) begin
                    if (bar_elapsed >= blink_iv) begin
                        bar_elapsed = '0;
                        bar_blinks = bar_blinks + 1'b1;
                        if (bar_blinks < blink_limit) begin
                            pat = bar_blinks[0] ? PATTERN_ALL_OFF : PATTERN_ALL_ON;
                        end else begin
                            pat = (bar_mode == MODE_DEPART) ? PATTERN_ALL_ON : PATTERN_ALL_OFF;
                            bar_mode = MODE_IDLE;
                        end
                        emit = 1'b1;
                    end
                end else if (bar_mode == MODE_UP) begin
                    if (bar_elapsed >= run_iv) begin
                        bar_elapsed = '0;
                        pat = band_bits(bar_pos, -1);
                        bar_pos = (bar_pos + 1) % LED_COUNT;
                        emit = 1'b1;
                    end
                end else if (bar_mode == MODE_DOWN) begin
                    if (bar_elapsed >= run_iv) begin
                        bar_elapsed = '0;
                        pat = band_bits(bar_pos, 1);
                        bar_pos = (bar_pos + LED_COUNT - 1) % LED_COUNT;
                        emit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            frame.pattern = pat;
            frame.mode = bar_mode;
            expected_frames.push_back(frame);
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        bar_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_bar_model(s_action, s_emergency);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_action <= req.action;
                    s_emergency <= req.emergency;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern and two long hold-offs.
    int rx_cycles = 0;
    int rx_style = 0;
    int hold_left = 0;
    int results_seen = 0;

    always @(posedge aclk) begin
        bar_frame_t exp_frame;
        logic       next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: pattern %h mode %0d", m_pattern, m_mode);
                    mismatches++;
                end else begin
                    exp_frame = expected_frames.pop_front();
                    if (m_pattern !== exp_frame.pattern) begin
                        $error("pattern: expected %h, actual %h", exp_frame.pattern, m_pattern);
                        mismatches++;
                    end
                    if (m_mode !== exp_frame.mode) begin
                        $error("mode: expected %0d, actual %0d", exp_frame.mode, m_mode);
                        mismatches++;
                    end
                end
                results_seen++;
                if (results_seen == 300 || results_seen == 900) begin
                    hold_left = 400;
                end
            end
            rx_cycles++;
            if (rx_cycles % 128 == 0) begin
                rx_style = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case (rx_style)
                    0: next_ready = 1'b1;
                    1: next_ready = 1'($urandom_range(0, 1));
                    2: next_ready = ($urandom_range(0, 3) == 0);
                    default: next_ready = rx_cycles[2];
                endcase
            end
            m_ready <= next_ready;
        end
    end

    task automatic push_request(input logic [ACTION_W-1:0] act, input logic emerg);
        bar_request_t req;
        req.action = act;
        req.emergency = emerg;
        pending_requests.push_back(req);
    endtask

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_valid || expected_frames.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RUN_INTERVAL:   run_iv = data;
            REG_BLINK_INTERVAL: blink_iv = data;
            REG_HALF_PERIOD:    flash_half = data;
            REG_BLINK_TRANS:    blink_limit = data[BLINK_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] run, input logic [15:0] blink,
                                  input logic [15:0] half, input logic [15:0] trans);
        write_register(REG_RUN_INTERVAL, run);
        write_register(REG_BLINK_INTERVAL, blink);
        write_register(REG_HALF_PERIOD, half);
        write_register(REG_BLINK_TRANS, trans);
        @(negedge aclk);
    endtask

    // Mostly a start command followed by a run of ticks, with noise and broken runs mixed in.
    task automatic queue_random_sequences(input int count, input int max_run);
        int queued;
        int run_len;
        int sel;
        queued = 0;
        while (queued < count) begin
            sel = $urandom_range(0, 19);
            if (sel < 2) begin
                push_request(3'($urandom_range(5, 7)), 1'($urandom_range(0, 1)));
            end else begin
                if (sel != 2) begin
                    push_request(3'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
                    queued++;
                end
                run_len = $urandom_range(1, max_run);
                if ($urandom_range(0, 7) == 0) begin
                    for (int i = 0; i < $urandom_range(2, 20); i++) begin
                        push_request(ACT_TICK, 1'b1);
                        queued++;
                    end
                end
                for (int i = 0; i < run_len; i++) begin
                    push_request(ACT_TICK, ($urandom_range(0, 9) == 0));
                    queued++;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_request(ACT_DEPART, 1'b0);
        push_request(ACT_TICK, 1'b1);
        wait_until_drained();

        apply_settings(16'd1, 16'd1, 16'd2, 16'd3);
        push_request(ACT_DEPART, 1'b1);
        repeat (3) push_request(ACT_TICK, 1'b0);
        push_request(ACT_ARRIVE, 1'b0);
        repeat (3) push_request(ACT_TICK, 1'b0);
        push_request(ACT_UP, 1'b0);
        repeat (2) push_request(ACT_TICK, 1'b0);
        push_request(ACT_DOWN, 1'b1);
        repeat (2) push_request(ACT_TICK, 1'b0);
        repeat (3) push_request(ACT_TICK, 1'b1);
        push_request(3'd5, 1'b1);
        push_request(3'd6, 1'b0);
        push_request(3'd7, 1'b1);
        push_request(ACT_TICK, 1'b0);
        wait_until_drained();

        for (int n = 0; n < 6; n++) begin
            apply_settings(16'($urandom_range(0, 5)), 16'($urandom_range(0, 4)),
                           16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
            queue_random_sequences(60, 24);
            wait_until_drained();
        end

        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        queue_random_sequences(80, 12);
        wait_until_drained();

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
        queue_random_sequences(60, 12);
        wait_until_drained();

        apply_settings(16'd1, 16'd0, 16'd1, 16'd255);
        push_request(ACT_ARRIVE, 1'b0);
        repeat (260) push_request(ACT_TICK, 1'b0);
        queue_random_sequences(100, 40);
        wait_until_drained();

        // The elapsed count keeps running during a flash, so the band steps on the first
        // quiet tick.
        apply_settings(16'd5, 16'd5, 16'd40, 16'd6);
        push_request(ACT_UP, 1'b0);
        repeat (30) push_request(ACT_TICK, 1'b1);
        push_request(ACT_TICK, 1'b0);
        push_request(ACT_TICK, 1'b0);
        wait_until_drained();

        // A smaller half period leaves the flash phase out of range until it wraps.
        apply_settings(16'd3, 16'd2, 16'd3, 16'd5);
        push_request(ACT_TICK, 1'b1);
        queue_random_sequences(60, 24);
        wait_until_drained();

        apply_settings(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                       16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)));
        queue_random_sequences(60, 24);
        wait_until_drained();

        repeat (10) @(negedge aclk);
        if (expected_frames.size() != 0) begin
            $error("%0d expected results never arrived", expected_frames.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
